// ===== design/qdd_pkg.sv =====
`default_nettype none
package qdd_pkg;

	// opcodes carried on s_tuser
	localparam logic [1:0] OP_EDGE    = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_CAPTURE = 2'd2;

	// configuration register indexes
	localparam logic [7:0] CFG_LOCKOUT = 8'd0;
	localparam logic [7:0] CFG_SPD     = 8'd1;

	localparam logic [15:0] LOCKOUT_RESET = 16'd800;
	localparam logic [2:0]  SPD_RESET     = 3'd2;

	// quadrature phase codes {A, B}
	localparam logic [1:0] PH_00 = 2'b00;
	localparam logic [1:0] PH_01 = 2'b01;
	localparam logic [1:0] PH_11 = 2'b11;
	localparam logic [1:0] PH_10 = 2'b10;

	// detent division: quotient bits resolved per cycle, iterations per division
	localparam int QUOT_W        = 8;
	localparam int BITS_PER_ITER = 2;
	localparam int DIV_ITERS     = QUOT_W / BITS_PER_ITER;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic div_step;
		logic finish;
		logic load_out;
	} qdd_cmd_t;

	typedef struct packed {
		logic div_needed;
	} qdd_sts_t;

	function automatic logic signed [1:0] step_of(input logic [1:0] prev, input logic [1:0] cur);
		logic signed [1:0] s;
		case ({prev, cur})
			{PH_00, PH_01}, {PH_01, PH_11}, {PH_11, PH_10}, {PH_10, PH_00}: s = 2'sd1;
			{PH_00, PH_10}, {PH_10, PH_11}, {PH_11, PH_01}, {PH_01, PH_00}: s = -2'sd1;
			default: s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== design/qdd_ctrl.sv =====
`default_nettype none
module qdd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire qdd_pkg::qdd_sts_t sts,
	output qdd_pkg::qdd_cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam int CNT_W = $clog2(qdd_pkg::DIV_ITERS);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.div_needed ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(qdd_pkg::DIV_ITERS - 1))
					state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== design/qdd_dpath.sv =====
`default_nettype none
module qdd_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [7:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire logic [1:0]        in_opcode,
	input  wire logic [31:0]       in_time,
	input  wire logic              in_pin_a,
	input  wire logic              in_pin_b,
	input  wire qdd_pkg::qdd_cmd_t cmd,
	output qdd_pkg::qdd_sts_t      sts,
	output logic [7:0]             detents
);

	localparam int QW = qdd_pkg::QUOT_W;

	// configuration
	logic [15:0] lockout_q;
	logic [2:0]  spd_q;
	logic [2:0]  spd_eff;

	// architectural state
	logic signed [7:0] delta_q;
	logic [1:0]        phase_q;
	logic [31:0]       last_time_q;
	logic signed [7:0] rem_q;

	// latched item and working registers
	logic [1:0]        op_q;
	logic [31:0]       time_q;
	logic [1:0]        ph_q;
	logic signed [8:0] acc_q;
	logic [QW-1:0]     sh_q;
	logic [2:0]        r_q;
	logic signed [7:0] res_q;
	logic [7:0]        out_q;

	// edge path
	logic [31:0]       elapsed;
	logic              edge_ok;
	logic signed [1:0] step;
	logic signed [8:0] sum9;
	logic signed [7:0] delta_sat;

	// read path
	logic signed [8:0] acc_new;
	logic [8:0]        acc_abs;

	// division step
	logic [QW-1:0] sh_nx;
	logic [2:0]    r_nx;
	logic [3:0]    trial;

	// finish
	logic signed [8:0]  q9;
	logic signed [7:0]  q_sat;
	logic signed [11:0] prod;
	logic signed [11:0] rem12;

	assign spd_eff = (spd_q == 3'd0) ? 3'd1 : spd_q;

	assign elapsed = time_q - last_time_q;
	assign edge_ok = (elapsed >= {16'd0, lockout_q});
	assign step    = qdd_pkg::step_of(phase_q, ph_q);
	assign sum9    = {delta_q[7], delta_q} + {{7{step[1]}}, step};

	always_comb begin
		if (sum9 > 9'sd127)
			delta_sat = 8'sd127;
		else if (sum9 < -9'sd128)
			delta_sat = -8'sd128;
		else
			delta_sat = sum9[7:0];
	end

	assign acc_new = {rem_q[7], rem_q} + {delta_q[7], delta_q};
	assign acc_abs = acc_new[8] ? -acc_new : acc_new;

	assign sts.div_needed = (op_q == qdd_pkg::OP_READ) && (delta_q != 8'sd0);

	// restoring division, two quotient bits per cycle
	always_comb begin
		sh_nx = sh_q;
		r_nx  = r_q;
		trial = '0;
		for (int i = 0; i < qdd_pkg::BITS_PER_ITER; i++) begin
			trial = {r_nx, sh_nx[QW-1]};
			sh_nx = {sh_nx[QW-2:0], 1'b0};
			if (trial >= {1'b0, spd_eff}) begin
				trial    = trial - {1'b0, spd_eff};
				sh_nx[0] = 1'b1;
			end
			r_nx = trial[2:0];
		end
	end

	assign q9 = acc_q[8] ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});

	always_comb begin
		if (q9 > 9'sd127)
			q_sat = 8'sd127;
		else if (q9 < -9'sd128)
			q_sat = -8'sd128;
		else
			q_sat = q9[7:0];
	end

	assign prod  = {{4{q_sat[7]}}, q_sat} * $signed({9'd0, spd_eff});
	assign rem12 = {{3{acc_q[8]}}, acc_q} - prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q   <= qdd_pkg::LOCKOUT_RESET;
			spd_q       <= qdd_pkg::SPD_RESET;
			delta_q     <= '0;
			phase_q     <= qdd_pkg::PH_00;
			last_time_q <= '0;
			rem_q       <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					qdd_pkg::CFG_LOCKOUT: lockout_q <= cfg_data;
					qdd_pkg::CFG_SPD:     spd_q     <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				case (op_q)
					qdd_pkg::OP_EDGE: begin
						if (edge_ok) begin
							last_time_q <= time_q;
							delta_q     <= delta_sat;
							phase_q     <= ph_q;
						end
					end
					qdd_pkg::OP_READ: delta_q <= '0;
					qdd_pkg::OP_CAPTURE: phase_q <= ph_q;
					default: ;
				endcase
			end
			// leftover stays below spd_eff in magnitude unless the quotient saturates; fits 8 bits
			if (cmd.finish)
				rem_q <= rem12[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= in_opcode;
			time_q <= in_time;
			ph_q   <= {in_pin_a, in_pin_b};
		end
		if (cmd.exec) begin
			acc_q <= acc_new;
			sh_q  <= acc_abs[QW-1:0];
			r_q   <= '0;
			res_q <= '0;
		end
		if (cmd.div_step) begin
			sh_q <= sh_nx;
			r_q  <= r_nx;
		end
		if (cmd.finish)
			res_q <= q_sat;
		if (cmd.load_out)
			out_q <= res_q;
	end

	assign detents = out_q;

endmodule
`default_nettype wire

// ===== design/quadrature_detent_decoder.sv =====
`default_nettype none
// Quadrature detent decoder.
// Input stream s_*: one transaction per command. s_tuser carries the opcode
// (edge, read detents, capture levels); s_tdata carries the timestamp and
// the A/B levels. Every transaction yields exactly one result on m_*, whose
// m_tdata holds the signed detent count (zero except for a productive read).
// Config channel cfg_*: cfg_index 0 = lockout in microseconds,
// 1 = steps per detent; always ready, write only while the block is idle.
// Timing: an item is taken only while the controller is idle, so a new
// item is not taken before the last one reaches the output register. Edge,
// capture and empty reads pass through exec and done; a read with pending
// steps also passes through div and fin, where the iterative detent divider
// resolves two quotient bits per cycle. m_tvalid rises once done loads the result.
// The result sits in an output register, so the next item is accepted while
// it waits; if m_tready stays low the controller holds the following result
// until the register frees and stops taking input in the meantime.
// Reset clears step count, remainder, phase and edge time, and restores the
// lockout (800) and steps per detent (2) defaults. No clearing pass.
module quadrature_detent_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] time_us, [32] pin_a, [33] pin_b, rest zero
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] detents
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	qdd_pkg::qdd_cmd_t cmd;
	qdd_pkg::qdd_sts_t sts;
	logic              s_ready_i;

	assign cfg_ready = 1'b1;
	assign s_tready  = s_ready_i;

	qdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_ready_i),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qdd_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_opcode(s_tuser),
		.in_time  (s_tdata[31:0]),
		.in_pin_a (s_tdata[32]),
		.in_pin_b (s_tdata[33]),
		.cmd      (cmd),
		.sts      (sts),
		.detents  (m_tdata)
	);

endmodule
`default_nettype wire
